FILE: hw/rtl/plin_pkg.sv
package plin_pkg;

   localparam int POINTS          = 3;
   localparam int DATA_WIDTH      = 32;
   localparam int COUNT_WIDTH     = 2;
   localparam int INDEX_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH = $clog2(2 * POINTS + 1);
   localparam int DIV_STEPS       = DATA_WIDTH - 1;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   // accepting edge to the edge that takes the result
   localparam int LATENCY         = DIV_STEPS + 8;

   // register map: count first, then x and y of each point in turn
   localparam int CSR_COUNT      = 0;
   localparam int CSR_POINT_BASE = 1;

   localparam logic [COUNT_WIDTH-1:0] RESET_COUNT = 2'd3;
   localparam logic [DATA_WIDTH-1:0]  RESET_X [3] = '{32'd0, 32'd6554, 32'd32768};
   localparam logic [DATA_WIDTH-1:0]  RESET_Y [3] = '{32'd3277, 32'd3277, 32'd6554};

   typedef enum logic [1:0] {
      SRC_EMPTY  = 2'd0,
      SRC_BELOW  = 2'd1,
      SRC_INTERP = 2'd2,
      SRC_HELD   = 2'd3
   } source_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]               count;
      logic [POINTS-1:0][DATA_WIDTH-1:0]    x;
      logic [POINTS-1:0][DATA_WIDTH-1:0]    y;
   } cfg_type;

   typedef struct packed {
      logic                   interp;
      logic [DATA_WIDTH-1:0]  base;
      source_type             source;
      logic [INDEX_WIDTH-1:0] index;
      logic [DATA_WIDTH:0]    dy;
      logic [DATA_WIDTH-1:0]  offset;
      logic [DATA_WIDTH-1:0]  dx;
   } job_type;

   typedef struct packed {
      logic                   valid;
      logic                   interp;
      logic                   neg;
      logic                   ovf;
      logic [DATA_WIDTH-1:0]  base;
      source_type             source;
      logic [INDEX_WIDTH-1:0] index;
      logic [DATA_WIDTH-1:0]  dx;
      logic [DATA_WIDTH-1:0]  rem;
      logic [DIV_STEPS-1:0]   quo;
      logic [DIV_STEPS-1:0]   low;
   } div_stage_type;

endpackage

FILE: hw/rtl/plin_front.sv
module plin_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [plin_pkg::DATA_WIDTH-1:0]     query_x,
   input  plin_pkg::cfg_type                   cfg,
   output logic                                push,
   output plin_pkg::job_type                   job
);

   logic                                                f1_valid_ff;
   logic [plin_pkg::DATA_WIDTH-1:0]                     f1_x_ff;
   logic                                                f2_valid_ff;
   logic [plin_pkg::POINTS-1:0]                         ge_ff, ge_in;
   logic [plin_pkg::DATA_WIDTH-1:0]                     offset_ff [plin_pkg::POINTS];
   logic [plin_pkg::DATA_WIDTH-1:0]                     offset_in [plin_pkg::POINTS];
   logic [plin_pkg::DATA_WIDTH-1:0]                     dx_ff   [plin_pkg::POINTS];
   logic [plin_pkg::DATA_WIDTH-1:0]                     dx_in   [plin_pkg::POINTS];
   logic [plin_pkg::DATA_WIDTH:0]                       dy_ff   [plin_pkg::POINTS];
   logic [plin_pkg::DATA_WIDTH:0]                       dy_in   [plin_pkg::POINTS];
   logic [plin_pkg::COUNT_WIDTH-1:0]                    n;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= in_valid;
         f2_valid_ff <= f1_valid_ff;
      end
      f1_x_ff   <= query_x;
      ge_ff     <= ge_in;
      offset_ff <= offset_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
   end

   // per-point compare and per-segment differences, all in parallel
   always_comb begin
      for (int i = 0; i < plin_pkg::POINTS; i++) begin
         ge_in[i]     = $signed(f1_x_ff) >= $signed(cfg.x[i]);
         offset_in[i] = f1_x_ff - cfg.x[i];
         dx_in[i]     = cfg.x[(i + 1) % plin_pkg::POINTS] - cfg.x[i];
         dy_in[i]     = {cfg.y[(i + 1) % plin_pkg::POINTS][plin_pkg::DATA_WIDTH-1],
                         cfg.y[(i + 1) % plin_pkg::POINTS]}
                      - {cfg.y[i][plin_pkg::DATA_WIDTH-1], cfg.y[i]};
      end
   end

   // classify: last matching point wins
   always_comb begin
      n = (cfg.count > plin_pkg::COUNT_WIDTH'(plin_pkg::POINTS)) ?
          plin_pkg::COUNT_WIDTH'(plin_pkg::POINTS) : cfg.count;
      job        = '0;
      job.source = plin_pkg::SRC_EMPTY;
      if (n != '0) begin
         if (!ge_ff[0]) begin
            job.base   = cfg.y[0];
            job.source = plin_pkg::SRC_BELOW;
         end else begin
            for (int i = 0; i < plin_pkg::POINTS; i++) begin
               if (i < int'(n) && ge_ff[i]) begin
                  if (i + 1 < int'(n)) begin
                     if (!ge_ff[(i + 1) % plin_pkg::POINTS]) begin
                        job.interp = 1'b1;
                        job.base   = cfg.y[i];
                        job.source = plin_pkg::SRC_INTERP;
                        job.index  = plin_pkg::INDEX_WIDTH'(i);
                        job.dy     = dy_ff[i];
                        job.offset = offset_ff[i];
                        job.dx     = dx_ff[i];
                     end
                  end else begin
                     job.interp = 1'b0;
                     job.base   = cfg.y[i];
                     job.source = plin_pkg::SRC_HELD;
                     job.index  = plin_pkg::INDEX_WIDTH'(i);
                  end
               end
            end
         end
      end
   end

   assign push = f2_valid_ff;

endmodule

FILE: hw/rtl/plin_queue.sv
module plin_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  plin_pkg::job_type  wr_data,
   input  logic               pop,
   output plin_pkg::job_type  rd_data,
   output logic               empty,
   output logic               full
);

   plin_pkg::job_type                       mem_ff [plin_pkg::QUEUE_DEPTH];
   logic [plin_pkg::QUEUE_PTR_WIDTH-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [plin_pkg::QUEUE_PTR_WIDTH:0]      count_ff;
   logic                                    do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (plin_pkg::QUEUE_PTR_WIDTH + 1)'(plin_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/plin_back.sv
module plin_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 avail,
   input  plin_pkg::job_type                    job,
   output logic                                 pop,
   output logic                                 rsp_strobe,
   output logic [plin_pkg::DATA_WIDTH-1:0]      rsp_value_y,
   output logic [1:0]                           rsp_source,
   output logic [plin_pkg::INDEX_WIDTH-1:0]     rsp_point_index
);

   localparam int W = plin_pkg::DATA_WIDTH;
   localparam int S = plin_pkg::DIV_STEPS;

   // b1: magnitude of dy
   logic                              b1_valid_ff;
   logic                              b1_interp_ff, b1_neg_ff;
   logic [W-1:0]                      b1_mag_ff, b1_offset_ff, b1_dx_ff, b1_base_ff;
   plin_pkg::source_type              b1_source_ff;
   logic [plin_pkg::INDEX_WIDTH-1:0]  b1_index_ff;
   // b2: product
   logic                              b2_valid_ff;
   logic                              b2_interp_ff, b2_neg_ff;
   logic [2*W-1:0]                    b2_prod_ff;
   logic [W-1:0]                      b2_dx_ff, b2_base_ff;
   plin_pkg::source_type              b2_source_ff;
   logic [plin_pkg::INDEX_WIDTH-1:0]  b2_index_ff;
   // divider stages
   plin_pkg::div_stage_type           st_ff [S+1];
   plin_pkg::div_stage_type           st_in [S+1];
   logic [W:0]                        trial [S];
   logic                              fits  [S];
   // signed quotient stage
   logic                              q_valid_ff, q_valid_in;
   logic                              q_interp_ff;
   logic [W-1:0]                      q_value_ff, q_value_in, q_base_ff;
   plin_pkg::source_type              q_source_ff;
   logic [plin_pkg::INDEX_WIDTH-1:0]  q_index_ff;
   // output
   logic                              out_valid_ff;
   logic [W-1:0]                      out_value_ff, out_value_in;
   plin_pkg::source_type              out_source_ff;
   logic [plin_pkg::INDEX_WIDTH-1:0]  out_index_ff;
   logic [W:0]                        sum;

   assign pop = avail;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= avail;
         b2_valid_ff <= b1_valid_ff;
      end
      b1_interp_ff <= job.interp;
      b1_neg_ff    <= job.dy[W];
      b1_mag_ff    <= job.dy[W] ? W'(-job.dy) : job.dy[W-1:0];
      b1_offset_ff <= job.offset;
      b1_dx_ff     <= job.dx;
      b1_base_ff   <= job.base;
      b1_source_ff <= job.source;
      b1_index_ff  <= job.index;

      b2_interp_ff <= b1_interp_ff;
      b2_neg_ff    <= b1_neg_ff;
      b2_prod_ff   <= (2*W)'(b1_mag_ff) * (2*W)'(b1_offset_ff);
      b2_dx_ff     <= b1_dx_ff;
      b2_base_ff   <= b1_base_ff;
      b2_source_ff <= b1_source_ff;
      b2_index_ff  <= b1_index_ff;
   end

   // restoring division, one quotient bit per stage; a quotient of 2^31 or
   // more is flagged up front and saturates later
   always_comb begin
      st_in[0].valid  = b2_valid_ff;
      st_in[0].interp = b2_interp_ff;
      st_in[0].neg    = b2_neg_ff;
      st_in[0].ovf    = b2_prod_ff[2*W-1:S] >= {1'b0, b2_dx_ff};
      st_in[0].base   = b2_base_ff;
      st_in[0].source = b2_source_ff;
      st_in[0].index  = b2_index_ff;
      st_in[0].dx     = b2_dx_ff;
      st_in[0].rem    = b2_prod_ff[2*W-2:S];
      st_in[0].quo    = '0;
      st_in[0].low    = b2_prod_ff[S-1:0];
      for (int k = 0; k < S; k++) begin
         trial[k]        = {st_ff[k].rem, st_ff[k].low[S-1]};
         fits[k]         = trial[k] >= {1'b0, st_ff[k].dx};
         st_in[k+1]      = st_ff[k];
         st_in[k+1].rem  = fits[k] ? W'(trial[k] - {1'b0, st_ff[k].dx}) : trial[k][W-1:0];
         st_in[k+1].quo  = {st_ff[k].quo[S-2:0], fits[k]};
         st_in[k+1].low  = {st_ff[k].low[S-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= S; k++) begin
            st_ff[k].valid <= 1'b0;
         end
      end else begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      q_valid_in = st_ff[S].valid;
      if (st_ff[S].ovf) begin
         q_value_in = st_ff[S].neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if (st_ff[S].neg) begin
         q_value_in = -{1'b0, st_ff[S].quo};
      end else begin
         q_value_in = {1'b0, st_ff[S].quo};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
      end
      q_value_ff  <= q_value_in;
      q_interp_ff <= st_ff[S].interp;
      q_base_ff   <= st_ff[S].base;
      q_source_ff <= st_ff[S].source;
      q_index_ff  <= st_ff[S].index;
   end

   // add to the segment start and saturate; a non-interpolating result passes the base through
   always_comb begin
      sum = {q_base_ff[W-1], q_base_ff} + {q_value_ff[W-1], q_value_ff};
      if (!q_interp_ff) begin
         out_value_in = q_base_ff;
      end else if (sum[W] != sum[W-1]) begin
         out_value_in = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         out_value_in = sum[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= q_valid_ff;
      end
      out_value_ff  <= out_value_in;
      out_source_ff <= q_source_ff;
      out_index_ff  <= q_index_ff;
   end

   assign rsp_strobe      = out_valid_ff;
   assign rsp_value_y     = out_value_ff;
   assign rsp_source      = out_source_ff;
   assign rsp_point_index = out_index_ff;

endmodule

FILE: hw/rtl/piecewise_linear_interpolator_core.sv
// Path: a query passes the front registers, the queue, the magnitude and product
// registers, the 31-stage restoring divider and the quotient and output registers.
// Throughput: one query per cycle; busy stays low, as the back end drains the
// queue every cycle and the receiver cannot stall.
// Reset (synchronous, active high) empties the pipeline and queue and loads
// the breakpoint registers with their default table.
module piecewise_linear_interpolator_core (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [plin_pkg::DATA_WIDTH-1:0]            req_query_x,
   output logic                                       rsp_strobe,
   output logic [plin_pkg::DATA_WIDTH-1:0]            rsp_value_y,
   output logic [1:0]                                 rsp_source,
   output logic [plin_pkg::INDEX_WIDTH-1:0]           rsp_point_index,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [plin_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [plin_pkg::DATA_WIDTH-1:0]            csr_data
);

   plin_pkg::cfg_type  cfg_ff;
   plin_pkg::job_type  front_job, queue_job;
   logic               accept, push, pop, empty, full;

   assign csr_ready = 1'b1;
   assign busy      = full;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count <= plin_pkg::RESET_COUNT;
         for (int k = 0; k < plin_pkg::POINTS; k++) begin
            cfg_ff.x[k] <= plin_pkg::RESET_X[k];
            cfg_ff.y[k] <= plin_pkg::RESET_Y[k];
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == plin_pkg::CSR_INDEX_WIDTH'(plin_pkg::CSR_COUNT)) begin
            cfg_ff.count <= csr_data[plin_pkg::COUNT_WIDTH-1:0];
         end
         for (int k = 0; k < plin_pkg::POINTS; k++) begin
            if (csr_index == plin_pkg::CSR_INDEX_WIDTH'(plin_pkg::CSR_POINT_BASE + 2*k)) begin
               cfg_ff.x[k] <= csr_data;
            end
            if (csr_index == plin_pkg::CSR_INDEX_WIDTH'(plin_pkg::CSR_POINT_BASE + 2*k + 1)) begin
               cfg_ff.y[k] <= csr_data;
            end
         end
      end
   end

   plin_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .query_x  (req_query_x),
      .cfg      (cfg_ff),
      .push     (push),
      .job      (front_job)
   );

   plin_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_job),
      .pop     (pop),
      .rd_data (queue_job),
      .empty   (empty),
      .full    (full)
   );

   plin_back u_back (
      .clock           (clock),
      .reset           (reset),
      .avail           (!empty),
      .job             (queue_job),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_value_y     (rsp_value_y),
      .rsp_source      (rsp_source),
      .rsp_point_index (rsp_point_index)
   );

endmodule

FILE: hw/rtl/plin_checker.sv
module plin_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic                                   rsp_strobe,
   input  logic [plin_pkg::DATA_WIDTH-1:0]        rsp_value_y,
   input  logic [1:0]                             rsp_source,
   input  logic [plin_pkg::INDEX_WIDTH-1:0]       rsp_point_index
);

   // no result survives a reset
   assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   // every result traces back to a transaction a fixed time earlier
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, plin_pkg::LATENCY))
      else $error("result without matching transaction");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_source == plin_pkg::SRC_EMPTY) |->
         (rsp_value_y == '0 && rsp_point_index == '0))
      else $error("empty table result not zero");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_source == plin_pkg::SRC_INTERP) |->
         (rsp_point_index < plin_pkg::INDEX_WIDTH'(plin_pkg::POINTS - 1)))
      else $error("interpolation from last point");

endmodule

bind piecewise_linear_interpolator_core plin_checker u_plin_checker (.*);
